@@ sv/modexp_pkg.sv @@
// Shared types and constants for the modular exponentiation block.
// Used by the controller, the datapath and the top level; depends on nothing.
package modexp_pkg;

    localparam logic [31:0] MODULUS_RESET = 32'd1000;

    // Register index of the modulus in the configuration map.
    localparam logic REG_MODULUS = 1'b0;

    // Datapath operation codes.
    localparam logic [3:0] DP_NOP   = 4'd0;
    localparam logic [3:0] DP_LOAD  = 4'd1;
    localparam logic [3:0] DP_RED   = 4'd2;
    localparam logic [3:0] DP_RINIT = 4'd3;
    localparam logic [3:0] DP_SQ    = 4'd4;
    localparam logic [3:0] DP_MUL   = 4'd5;
    localparam logic [3:0] DP_DBL   = 4'd6;
    localparam logic [3:0] DP_ADD   = 4'd7;
    localparam logic [3:0] DP_FIN   = 4'd8;
    localparam logic [3:0] DP_ONE   = 4'd9;
    localparam logic [3:0] DP_OUT   = 4'd10;

    typedef struct packed {
        logic [3:0] op;
        logic       exp_shift;
    } cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_msb;
    } sts_t;

endpackage

@@ sv/modexp_dp.sv @@
// Datapath of the modular exponentiation block: operand, exponent, accumulator
// registers and one shared modular adder. Depends on modexp_pkg.
module modexp_dp
    import modexp_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [WORD_BITS-1:0] modulus,
    input  logic [31:0]          base_value,
    input  logic [31:0]          power,
    output logic [31:0]          residue
);

    localparam int CW = (WORD_BITS < 32) ? WORD_BITS : 32;

    logic [WORD_BITS-1:0] base_reg, base_next;
    logic [WORD_BITS-1:0] exp_reg, exp_next;
    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [31:0]          out_reg, out_next;

    logic [WORD_BITS-1:0] add_x, add_y, add_res;
    logic                 add_cin;
    logic [WORD_BITS:0]   sum, sum_red;
    logic                 wrap;
    logic                 b_msb;

    assign wrap  = (modulus == '0);
    assign b_msb = b_reg[WORD_BITS-1];

    // Shared (x + y + cin) mod m; with a zero modulus the sum wraps to the word.
    always_comb
    begin
        add_x   = acc_reg;
        add_y   = acc_reg;
        add_cin = 1'b0;
        case (cmd.op)
            DP_RED:  add_cin = b_msb;
            DP_ADD:  add_y   = a_reg;
            default: add_cin = 1'b0;
        endcase
        sum     = {1'b0, add_x} + {1'b0, add_y} + {{WORD_BITS{1'b0}}, add_cin};
        sum_red = sum - {1'b0, modulus};
        if (!wrap && (sum >= {1'b0, modulus}))
            add_res = sum_red[WORD_BITS-1:0];
        else
            add_res = sum[WORD_BITS-1:0];
    end

    always_comb
    begin
        base_next = base_reg;
        exp_next  = exp_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        out_next  = out_reg;
        case (cmd.op)
            DP_LOAD:
            begin
                b_next   = WORD_BITS'(base_value[CW-1:0]);
                exp_next = WORD_BITS'(power[CW-1:0]);
                acc_next = '0;
            end
            DP_RED:
            begin
                acc_next = add_res;
                b_next   = {b_reg[WORD_BITS-2:0], 1'b0};
            end
            DP_RINIT:
            begin
                base_next = acc_reg;
                r_next    = (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            end
            DP_SQ:
            begin
                a_next   = r_reg;
                b_next   = r_reg;
                acc_next = '0;
            end
            DP_MUL:
            begin
                a_next   = r_reg;
                b_next   = base_reg;
                acc_next = '0;
            end
            DP_DBL:  acc_next = add_res;
            DP_ADD:
            begin
                if (b_msb)
                    acc_next = add_res;
                b_next = {b_reg[WORD_BITS-2:0], 1'b0};
            end
            DP_FIN:  r_next   = acc_reg;
            DP_ONE:  r_next   = WORD_BITS'(1);
            DP_OUT:  out_next = 32'(r_reg);
            default: out_next = out_reg;
        endcase
        if (cmd.exp_shift)
            exp_next = {exp_reg[WORD_BITS-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        r_reg    <= r_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
    end

    assign sts.exp_zero = (exp_reg == '0);
    assign sts.exp_msb  = exp_reg[WORD_BITS-1];
    assign residue      = out_reg;

endmodule

@@ sv/modexp_ctrl.sv @@
// Controller of the modular exponentiation block: sequences the base reduction,
// the square and multiply steps and the output handshake. Depends on modexp_pkg.
module modexp_ctrl
    import modexp_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(WORD_BITS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_RED   = 4'd2;
    localparam logic [3:0] S_RINIT = 4'd3;
    localparam logic [3:0] S_SQS   = 4'd4;
    localparam logic [3:0] S_DBL   = 4'd5;
    localparam logic [3:0] S_ADD   = 4'd6;
    localparam logic [3:0] S_MFIN  = 4'd7;
    localparam logic [3:0] S_MULS  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] ecnt_reg, ecnt_next;
    logic             phase_reg, phase_next;
    logic             ovalid_reg, ovalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ecnt_next     = ecnt_reg;
        phase_next    = phase_reg;
        ovalid_next   = ovalid_reg;
        cmd.op        = DP_NOP;
        cmd.exp_shift = 1'b0;
        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.exp_zero)
                begin
                    cmd.op     = DP_ONE;
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next   = CNT_TOP;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                cmd.op   = DP_RED;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_RINIT;
            end
            S_RINIT:
            begin
                cmd.op     = DP_RINIT;
                ecnt_next  = CNT_TOP;
                state_next = S_SQS;
            end
            S_SQS:
            begin
                cmd.op     = DP_SQ;
                cnt_next   = CNT_TOP;
                phase_next = 1'b0;
                state_next = S_DBL;
            end
            S_MULS:
            begin
                cmd.op     = DP_MUL;
                cnt_next   = CNT_TOP;
                phase_next = 1'b1;
                state_next = S_DBL;
            end
            S_DBL:
            begin
                cmd.op     = DP_DBL;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.op   = DP_ADD;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_MFIN;
                else
                    state_next = S_DBL;
            end
            S_MFIN:
            begin
                cmd.op = DP_FIN;
                // After the square, a set exponent bit calls for a multiply by the base.
                if (!phase_reg && sts.exp_msb)
                    state_next = S_MULS;
                else
                begin
                    cmd.exp_shift = 1'b1;
                    ecnt_next     = ecnt_reg - 1'b1;
                    if (ecnt_reg == '0)
                        state_next = S_FIN;
                    else
                        state_next = S_SQS;
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    cmd.op      = DP_OUT;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ecnt_reg   <= '0;
            phase_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ecnt_reg   <= ecnt_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

@@ sv/modular_exponentiation.sv @@
// Top level of the modular exponentiation block: modulus register, controller
// and datapath. Depends on modexp_pkg, modexp_ctrl and modexp_dp.
//
//  Channel   Direction  Contents
//  s_*       in         one item: base_value, power
//  m_*       out        one item: residue
//  APB       in/out     modulus register at byte address 0
//
// An item with power zero goes straight to its result. Otherwise the block first
// reduces the base bit by bit and then, for each of the WORD_BITS exponent bits,
// squares and, when the bit is one, multiplies by the base. The run time is set by
// the shift-and-add modular multiply, which handles one multiplier bit with a double
// step and an add step.
// Reset sets the modulus to 1000 and empties the output register. A finished
// result waits in the output register while the next item is accepted.
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] base_value, [63:32] power
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] residue
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = (WORD_BITS < 32) ? WORD_BITS : 32;

    logic [WORD_BITS-1:0] mod_reg, mod_next;
    cmd_t                 cmd;
    sts_t                 sts;

    assign pready = 1'b1;

    always_comb
    begin
        mod_next = mod_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_MODULUS))
            mod_next = WORD_BITS'(pwdata[CW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= WORD_BITS'(MODULUS_RESET[CW-1:0]);
        else
            mod_reg <= mod_next;
    end

    assign prdata = (paddr[2] == REG_MODULUS) ? 32'(mod_reg) : 32'd0;

    modexp_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    modexp_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .sts        (sts),
        .modulus    (mod_reg),
        .base_value (s_tdata[31:0]),
        .power      (s_tdata[63:32]),
        .residue    (m_tdata)
    );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for modular_exponentiation: streams base/power items in,
// predicts each residue and checks it against the result stream.
// Depends on the RTL top level and on modexp_pkg for the register index and the reset modulus.
`timescale 1ns / 1ps

module tb_top
    import modexp_pkg::*;
();

    localparam int          HOLD_CYCLES    = 20000;
    localparam int          WATCHDOG_LIMIT = 100000;
    localparam int          TAIL_CYCLES    = 4500;
    localparam logic [2:0]  MODULUS_ADDR   = {REG_MODULUS, 2'b00};

    typedef struct packed {
        logic [31:0] power;
        logic [31:0] base_value;
    } operand_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;      // [31:0] base_value, [63:32] power
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] residue
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    operand_t    operand_q[$];
    logic [31:0] residue_q[$];
    logic [31:0] modulus_cfg = MODULUS_RESET;
    int          send_gap = 0;
    int          rx_stall = 0;
    int          hold_left = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          quiet_cycles = 0;
    int          mismatches = 0;
    int          reg_errors = 0;

    modular_exponentiation dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // A modulus of zero means arithmetic modulo 2^32; a zero power always gives 1.
    function automatic logic [31:0] pow_mod_residue(input logic [31:0] base_value,
                                                    input logic [31:0] power,
                                                    input logic [31:0] modulus);
        logic [63:0] acc;
        logic [63:0] b;
        logic [63:0] m;
        logic [63:0] prod;
        if (power == 32'd0)
            return 32'd1;
        m = {32'd0, modulus};
        b = (modulus == 32'd0) ? {32'd0, base_value} : {32'd0, base_value} % m;
        acc = (modulus == 32'd0) ? 64'd1 : 64'd1 % m;
        for (int i = 31; i >= 0; i--)
        begin
            prod = acc * acc;
            acc = (modulus == 32'd0) ? {32'd0, prod[31:0]} : prod % m;
            if (power[i])
            begin
                prod = acc * b;
                acc = (modulus == 32'd0) ? {32'd0, prod[31:0]} : prod % m;
            end
        end
        return acc[31:0];
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // Sender: presents queued items and records the expected residue on acceptance.
    always @(posedge clk)
    begin : sender
        operand_t nxt;
        operand_t cur;
        logic     vld;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            vld = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                cur = s_tdata;
                residue_q.insert(residue_q.size(),
                                 pow_mod_residue(cur.base_value, cur.power, modulus_cfg));
                vld = 1'b0;
            end
            if (!vld)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (operand_q.size() > 0)
                begin
                    nxt = operand_q.pop_front();
                    s_tdata <= nxt;
                    vld = 1'b1;
                    send_gap = pick_gap();
                end
            end
            s_tvalid <= vld;
        end
    end

    // Receiver and checker: throttles m_tready and compares each residue in order.
    always @(posedge clk)
    begin : receiver
        logic [31:0] want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (residue_q.size() == 0)
                begin
                    $error("residue: unexpected item, actual %0d", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = residue_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        $error("residue: expected %0d, actual %0d", want, m_tdata);
                        mismatches++;
                    end
                end
                rx_stall = pick_gap();
            end
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= MODULUS_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_modulus();
        logic [31:0] rd;
        apb_access(1'b0, 32'd0, rd);
        if (rd !== modulus_cfg)
        begin
            $error("modulus: expected %0d, actual %0d", modulus_cfg, rd);
            reg_errors++;
        end
    endtask

    // Only called while nothing is in flight.
    task automatic write_modulus(input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, value, unused);
        modulus_cfg = value;
        check_modulus();
    endtask

    task automatic push_item(input logic [31:0] base_value, input logic [31:0] power);
        operand_t item;
        item.base_value = base_value;
        item.power = power;
        operand_q.insert(operand_q.size(), item);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (operand_q.size() != 0 || residue_q.size() != 0 || s_tvalid)
            @(negedge clk);
    endtask

    task automatic queue_random(input int count);
        logic [31:0] b;
        logic [31:0] p;
        int          k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 9);
            case (k)
                6:       b = $urandom_range(0, 3);
                7:       b = 32'hFFFF_FFFF;
                8:       b = modulus_cfg + $urandom_range(0, 2);
                default: b = $urandom;
            endcase
            k = $urandom_range(0, 9);
            case (k)
                6, 7:    p = $urandom_range(0, 40);
                8:       p = 32'd0;
                9:       p = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF
                                                         : 32'd1 << $urandom_range(0, 31);
                default: p = $urandom;
            endcase
            push_item(b, p);
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] phase_mod[8];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_modulus();

        // Reset modulus of 1000.
        @(negedge clk);
        push_item(32'd0, 32'd0);
        push_item(32'd0, 32'd1);
        push_item(32'd2, 32'd10);
        push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(32'hFFFF_FFFF, 32'd0);
        push_item(32'd123456789, 32'd1);
        push_item(32'd1, 32'hFFFF_FFFF);
        push_item(32'd7, 32'h8000_0000);
        wait_drained();

        // A modulus of one gives zero unless the power is zero.
        write_modulus(32'd1);
        @(negedge clk);
        push_item(32'd5, 32'd0);
        push_item(32'd5, 32'd3);
        wait_drained();

        // Zero modulus wraps to the word.
        write_modulus(32'd0);
        @(negedge clk);
        push_item(32'd3, 32'hFFFF_FFFF);
        push_item(32'hFFFF_FFFF, 32'd2);
        push_item(32'd2, 32'd32);
        push_item(32'd0, 32'd0);
        wait_drained();

        write_modulus(32'hFFFF_FFFF);
        @(negedge clk);
        push_item(32'hFFFF_FFFF, 32'd5);
        push_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        wait_drained();

        // Above 65535 the squares no longer fit in 32 bits.
        write_modulus(32'd65537);
        @(negedge clk);
        push_item(32'd65536, 32'd2);
        push_item(32'd65536, 32'hFFFF_FFFF);
        wait_drained();

        phase_mod[0] = $urandom;
        phase_mod[1] = 32'd2;
        phase_mod[2] = 32'd1000;
        phase_mod[3] = 32'd0;
        phase_mod[4] = 32'hFFFF_FFFF;
        phase_mod[5] = $urandom_range(3, 100);
        phase_mod[6] = $urandom_range(65536, 1 << 20);
        phase_mod[7] = 32'd1;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_modulus(phase_mod[ph]);
            @(negedge clk);
            // Hold the result side off long enough for the block to back up its input.
            if (ph == 2)
                hold_req = 1'b1;
            queue_random(15);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && reg_errors == 0 && residue_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
